>>> hdl/rse_pkg.sv
// shared types and constants of the rgb sobel edge magnitude block
package rse_pkg;

  localparam int DEF_MAX_WIDTH = 2048;
  localparam int CFG_W         = 12;
  localparam int PIX_W         = 24;
  localparam int CH_W          = 8;
  localparam int ROW_W         = 13;
  localparam int GRAD_W        = 12;
  localparam int SQ_W          = 21;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

  // register index taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // input kind carried in tuser
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic accept;    // request taken, start line buffer read
    logic rd;        // shift window, write line buffer, step counters
    logic grad;      // form gx and gy
    logic square;    // form gx*gx + gy*gy
    logic root;      // one root iteration
    logic out_load;  // load output register
  } cmd_t;

  typedef struct packed {
    logic ignore;     // drain tick inside the frame
    logic emit;       // this request produces a result
    logic root_last;  // last root iteration
    logic out_busy;   // output register still held
  } status_t;

endpackage

>>> hdl/rgb_sobel_edge_magnitude.sv
// top level of the rgb sobel edge magnitude block
// usage:
//   slave stream takes pixels in raster order: tdata holds red, green, blue
//   (8 bits each, red lowest), tuser marks a drain tick after the frame.
//   master stream gives per channel edge magnitudes in the same order, with
//   tlast on the result for the frame's final pixel.
//   the result of a pixel comes out once its lower-right neighbour arrives;
//   after the last pixel, width+1 drain ticks flush the rest of the frame.
// sequence:
//   one request at a time; a request with no result passes line buffer
//   read and window shift, one with a result goes on through gradient,
//   square and 8 root iterations until the output register loads.
//   the bit-serial square root is the longest step of each result.
// reset and stall:
//   reset clears the counters, the window and the output valid and loads
//   width 640, height 480; line buffers are not cleared.
//   a held result does not stop the next request from being taken; only the
//   following load of the output register waits for the receiver.
//   an apb write to either size register restarts the frame.
module rgb_sobel_edge_magnitude #(
  parameter int MAX_WIDTH = rse_pkg::DEF_MAX_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  // slave stream
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [rse_pkg::PIX_W-1:0] s_tdata,   // red_in, green_in, blue_in
  input  logic                      s_tuser,   // kind
  // master stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [rse_pkg::PIX_W-1:0] m_tdata,   // red_edge, green_edge, blue_edge
  output logic                      m_tlast,   // frame_end
  // apb configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import rse_pkg::*;

  cmd_t             cmd;
  status_t          st;
  logic [CFG_W-1:0] frame_width, frame_height;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // size registers, word decoded on paddr[2]
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FRAME_WIDTH) begin
        frame_width <= pwdata[CFG_W-1:0];
      end else begin
        frame_height <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? {20'd0, frame_height}
                                                 : {20'd0, frame_width};

  rse_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .st      (st),
    .cmd     (cmd)
  );

  rse_datapath #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .restart     (cfg_wr),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule

>>> hdl/rse_ram.sv
// generic single write port ram with registered read
module rse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/rse_ctrl.sv
// sequencing state machine of the rgb sobel edge magnitude block
module rse_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  rse_pkg::status_t st,
  output rse_pkg::cmd_t    cmd
);
  import rse_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_GRAD = 6'b000100,
    S_SQ   = 6'b001000,
    S_ROOT = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (!st.ignore) begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = st.emit ? S_GRAD : S_IDLE;
      end
      S_GRAD: begin
        cmd.grad   = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root = 1'b1;
        if (st.root_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/rse_datapath.sv
// line buffers, window, gradient, root unit and output register
module rse_datapath #(
  parameter int MAX_WIDTH = rse_pkg::DEF_MAX_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rse_pkg::cmd_t              cmd,
  output rse_pkg::status_t           st,
  input  logic [rse_pkg::CFG_W-1:0]  frame_width,
  input  logic [rse_pkg::CFG_W-1:0]  frame_height,
  input  logic                       restart,
  input  logic [rse_pkg::PIX_W-1:0]  s_tdata,
  input  logic                       s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [rse_pkg::PIX_W-1:0]  m_tdata,
  output logic                       m_tlast
);
  import rse_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);

  logic [COL_W-1:0] in_col, out_col;
  logic [ROW_W-1:0] in_row;
  logic [CFG_W-1:0] out_row;
  logic [WW-1:0]    eff_w;
  logic [CFG_W-1:0] eff_h;
  logic             flushing, emit, fin;
  logic [WW-1:0]    in_col_inc, out_col_inc;
  logic [PIX_W-1:0] pix;
  logic [2*PIX_W-1:0] ram_rdata;
  logic [PIX_W-1:0] win [3][3];
  logic [2:0]       rok, cok;
  logic             fin_r;

  logic signed [GRAD_W-1:0] vv [3][3][3];
  logic signed [GRAD_W-1:0] gx_c [3];
  logic signed [GRAD_W-1:0] gy_c [3];
  logic signed [GRAD_W-1:0] gx [3];
  logic signed [GRAD_W-1:0] gy [3];
  logic signed [2*GRAD_W-1:0] px [3];
  logic signed [2*GRAD_W-1:0] py [3];
  logic [SQ_W-1:0]  sq [3];
  logic [CH_W-1:0]  rt [3];
  logic [CH_W-1:0]  tr [3];
  logic [2*CH_W-1:0] tt [3];
  logic [2:0]       k;

  // effective frame size
  always_comb begin
    if (frame_width == '0) begin
      eff_w = WW'(1);
    end else if ({20'd0, frame_width} > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
    eff_h = (frame_height == '0) ? CFG_W'(1) : frame_height;
  end

  assign flushing    = in_row >= {1'b0, eff_h};
  assign emit        = (in_row >= ROW_W'(2)) || (in_row == ROW_W'(1) && in_col != '0);
  assign in_col_inc  = WW'(in_col) + WW'(1);
  assign out_col_inc = WW'(out_col) + WW'(1);
  assign fin         = emit && ({1'b0, out_row} + ROW_W'(1) >= {1'b0, eff_h})
                       && (out_col_inc >= eff_w);

  assign st.ignore    = (s_tuser == KIND_DRAIN) && !flushing;
  assign st.emit      = emit;
  assign st.root_last = (k == 3'd0);
  assign st.out_busy  = m_tvalid && !m_tready;

  rse_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (cmd.rd),
    .waddr(in_col),
    .wdata({ram_rdata[PIX_W-1:0], pix}),
    .re   (cmd.accept),
    .raddr(in_col),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix <= flushing ? '0 : s_tdata;
    end
  end

  // counters and window
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else begin
      if (cmd.rd) begin
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= ram_rdata[2*PIX_W-1:PIX_W];
        win[1][2] <= ram_rdata[PIX_W-1:0];
        win[2][2] <= pix;
        if (fin) begin
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end else begin
          if (in_col_inc >= eff_w) begin
            in_col <= '0;
            in_row <= in_row + ROW_W'(1);
          end else begin
            in_col <= COL_W'(in_col_inc);
          end
          if (emit) begin
            if (out_col_inc >= eff_w) begin
              out_col <= '0;
              out_row <= out_row + CFG_W'(1);
            end else begin
              out_col <= COL_W'(out_col_inc);
            end
          end
        end
      end
      // final result frees the window once gradients are taken
      if (cmd.grad && fin_r) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            win[r][c] <= '0;
          end
        end
      end
    end
  end

  // edge masks for the result being formed
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rok[0] <= out_row != '0;
      rok[1] <= 1'b1;
      rok[2] <= !({1'b0, out_row} + ROW_W'(1) >= {1'b0, eff_h});
      cok[0] <= out_col != '0;
      cok[1] <= 1'b1;
      cok[2] <= !(out_col_inc >= eff_w);
      fin_r  <= fin;
    end
  end

  // sobel sums per channel
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          vv[ch][r][c] = (rok[r] && cok[c])
                         ? $signed({4'd0, win[r][c][ch*CH_W +: CH_W]}) : '0;
        end
      end
      gx_c[ch] = vv[ch][0][2] - vv[ch][0][0]
               + ((vv[ch][1][2] - vv[ch][1][0]) <<< 1)
               + vv[ch][2][2] - vv[ch][2][0];
      gy_c[ch] = vv[ch][2][0] - vv[ch][0][0]
               + ((vv[ch][2][1] - vv[ch][0][1]) <<< 1)
               + vv[ch][2][2] - vv[ch][0][2];
      px[ch]   = gx[ch] * gx[ch];
      py[ch]   = gy[ch] * gy[ch];
      tr[ch]   = rt[ch] | (CH_W'(1) << k);
      tt[ch]   = tr[ch] * tr[ch];
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd.grad) begin
        gx[ch] <= gx_c[ch];
        gy[ch] <= gy_c[ch];
      end
      if (cmd.square) begin
        sq[ch] <= SQ_W'(px[ch]) + SQ_W'(py[ch]);
        rt[ch] <= '0;
      end else if (cmd.root) begin
        if (tt[ch] <= sq[ch][2*CH_W-1:0]) begin
          rt[ch] <= tr[ch];
        end
      end
    end
    if (cmd.square) begin
      k <= 3'd7;
    end else if (cmd.root) begin
      k <= k - 3'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int ch = 0; ch < 3; ch++) begin
        m_tdata[ch*CH_W +: CH_W] <= (sq[ch][SQ_W-1:2*CH_W] != '0) ? '1 : rt[ch];
      end
      m_tlast <= fin_r;
    end
  end

endmodule

>>> tb/tb_rgb_sobel_edge_magnitude.sv
// self-checking testbench of the rgb sobel edge magnitude block
`timescale 1ns / 1ps

module tb_rgb_sobel_edge_magnitude;
  import rse_pkg::*;

  localparam int MAXW = DEF_MAX_WIDTH;

  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } edge_res_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;    // red_in, green_in, blue_in
  logic        s_tuser;    // kind
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;    // red_edge, green_edge, blue_edge
  logic        m_tlast;    // frame_end
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rgb_sobel_edge_magnitude i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [11:0] cfg_width, cfg_height;
  logic [23:0] upper_buf [MAXW];
  logic [23:0] middle_buf [MAXW];
  logic [23:0] win [3][3];
  int unsigned in_col, in_row, out_col, out_row;

  pixel_req_t pending_reqs[$];
  edge_res_t  expected_edges[$];
  int         error_count;

  // idling control
  bit quiet_mode;
  bit sender_hold;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic int unsigned width_used();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAXW) return MAXW;
    return cfg_width;
  endfunction

  function automatic int unsigned height_used();
    return (cfg_height == 0) ? 1 : cfg_height;
  endfunction

  function automatic void restart_frame();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) win[r][c] = '0;
  endfunction

  function automatic logic [7:0] sat_root(input int unsigned s);
    int unsigned r;
    int unsigned t;
    r = 0;
    if (s >= 65536) return 8'd255;
    for (int b = 7; b >= 0; b--) begin
      t = r | (1 << b);
      if (t * t <= s) r = t;
    end
    return r[7:0];
  endfunction

  // gradient magnitude of one channel with out-of-frame neighbours masked
  function automatic logic [7:0] channel_mag(input int shift, input bit rok[3],
                                              input bit cok[3]);
    int gx, gy, v;
    int kx [3][3];
    int ky [3][3];
    kx = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
    ky = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};
    gx = 0; gy = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        if (!rok[r] || !cok[c]) continue;
        v = (win[r][c] >> shift) & 8'hff;
        gx += v * kx[r][c];
        gy += v * ky[r][c];
      end
    return sat_root(gx * gx + gy * gy);
  endfunction

  // advance the predictor by one accepted request
  function automatic void predict_edges(input pixel_req_t req);
    int unsigned w, h, c;
    bit flushing, emit;
    logic [23:0] data;
    bit rok[3], cok[3];
    edge_res_t res;
    w = width_used();
    h = height_used();
    flushing = in_row >= h;
    if (req.kind == KIND_DRAIN && !flushing) return;
    data = flushing ? 24'd0 : {req.red, req.green, req.blue};
    emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
    c = in_col % MAXW;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = upper_buf[c];
    win[1][2] = middle_buf[c];
    win[2][2] = data;
    upper_buf[c] = middle_buf[c];
    middle_buf[c] = data;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return;
    for (int k = 0; k < 3; k++) begin
      rok[k] = !((k == 0 && out_row == 0) || (k == 2 && out_row + 1 >= h));
      cok[k] = !((k == 0 && out_col == 0) || (k == 2 && out_col + 1 >= w));
    end
    res.red   = channel_mag(16, rok, cok);
    res.green = channel_mag(8, rok, cok);
    res.blue  = channel_mag(0, rok, cok);
    if (out_row + 1 >= h && out_col + 1 >= w) begin
      res.last = 1'b1;
      restart_frame();
    end else begin
      res.last = 1'b0;
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    expected_edges.push_back(res);
  endfunction

  // driver: red sits in the low byte of tdata
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_edges({s_tuser, s_tdata[7:0], s_tdata[15:8],
                                               s_tdata[23:16]});
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() > 0 && !sender_hold &&
            (quiet_mode || $urandom_range(99) >= 17)) begin
          pixel_req_t nx;
          nx = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= nx.kind;
          s_tdata  <= {nx.blue, nx.green, nx.red};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_edges.size() == 0) begin
          report("result with nothing expected");
        end else begin
          edge_res_t ex;
          ex = expected_edges.pop_front();
          if (m_tdata[7:0] !== ex.red)
            report($sformatf("red got %0d want %0d", m_tdata[7:0], ex.red));
          if (m_tdata[15:8] !== ex.green)
            report($sformatf("green got %0d want %0d", m_tdata[15:8], ex.green));
          if (m_tdata[23:16] !== ex.blue)
            report($sformatf("blue got %0d want %0d", m_tdata[23:16], ex.blue));
          if (m_tlast !== ex.last)
            report($sformatf("frame end got %b want %b", m_tlast, ex.last));
        end
      end
      m_tready <= quiet_mode || ($urandom_range(99) >= 17);
    end
  end

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || s_tvalid || expected_edges.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // register write while idle; restarts the frame in the predictor
  task automatic write_reg(input logic idx, input logic [11:0] val);
    wait_idle();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {20'($urandom_range(1048575)), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_FRAME_WIDTH) cfg_width = val;
    else cfg_height = val;
    restart_frame();
    @(posedge clk);
  endtask

  function automatic pixel_req_t rand_pix();
    pixel_req_t p;
    p.kind  = 1'b0;
    p.red   = $urandom_range(255);
    p.green = $urandom_range(255);
    p.blue  = $urandom_range(255);
    return p;
  endfunction

  // queue one frame; style picks random, extreme or flat content
  task automatic queue_frame(input int w, input int h, input int style);
    pixel_req_t p;
    int wu;
    wu = (w == 0) ? 1 : ((w > MAXW) ? MAXW : w);
    for (int i = 0; i < wu * ((h == 0) ? 1 : h); i++) begin
      p = rand_pix();
      if (style == 1) p = ($urandom_range(1)) ? {1'b0, 24'hffffff} : '0;
      if (style == 2) p = {1'b0, 24'hffffff};
      // a drain tick inside the frame is ignored
      if ($urandom_range(30) == 0) pending_reqs.push_back({1'b1, 24'($urandom)});
      pending_reqs.push_back(p);
    end
    for (int i = 0; i < wu + 1; i++) begin
      p = rand_pix();
      // a pixel during the flush acts as a drain tick
      p.kind = ($urandom_range(3) == 0) ? 1'b0 : 1'b1;
      pending_reqs.push_back(p);
    end
  endtask

  initial begin
    int sent;
    int w, h;
    bit held;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0; m_tready = 1'b0;
    quiet_mode = 1'b0; sender_hold = 1'b0; error_count = 0; held = 1'b0;
    cfg_width = WIDTH_RESET; cfg_height = HEIGHT_RESET;
    for (int i = 0; i < MAXW; i++) begin
      upper_buf[i] = '0;
      middle_buf[i] = '0;
    end
    restart_frame();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: tiny and degenerate sizes with flat, extreme and random content
    write_reg(REG_FRAME_WIDTH, 12'd1);
    write_reg(REG_FRAME_HEIGHT, 12'd1);
    queue_frame(1, 1, 2);
    write_reg(REG_FRAME_WIDTH, 12'd0);
    write_reg(REG_FRAME_HEIGHT, 12'd0);
    queue_frame(0, 0, 0);
    write_reg(REG_FRAME_WIDTH, 12'd3);
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    queue_frame(3, 3, 1);
    write_reg(REG_FRAME_HEIGHT, 12'd2);
    queue_frame(3, 2, 2);

    // random frames, mostly small
    sent = 0;
    while (sent < 1450) begin
      if ($urandom_range(7) == 0) begin
        w = $urandom_range(40, 1);
        h = $urandom_range(2, 1);
      end else begin
        w = $urandom_range(9, 1);
        h = $urandom_range(9, 1);
      end
      quiet_mode = ($urandom_range(5) == 0);
      write_reg(REG_FRAME_WIDTH, w[11:0]);
      write_reg(REG_FRAME_HEIGHT, h[11:0]);
      queue_frame(w, h, $urandom_range(4) == 0 ? 1 : 0);
      sent += w * h + w + 1;
      // sender pauses until all results are in
      if (!held && sent > 800) begin
        held = 1'b1;
        sender_hold = 1'b1;
        while (expected_edges.size() > 0) @(posedge clk);
        sender_hold = 1'b0;
      end
    end
    quiet_mode = 1'b0;

    // extreme sizes: clamped width and tallest height, frames abandoned early
    write_reg(REG_FRAME_WIDTH, 12'd4095);
    write_reg(REG_FRAME_HEIGHT, 12'd1);
    for (int i = 0; i < 30; i++) pending_reqs.push_back(rand_pix());
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 12'd1);
    write_reg(REG_FRAME_HEIGHT, 12'd4095);
    for (int i = 0; i < 40; i++) pending_reqs.push_back(rand_pix());
    wait_idle();
    // abandoned frame: partial data, then a restart
    write_reg(REG_FRAME_WIDTH, 12'd5);
    write_reg(REG_FRAME_HEIGHT, 12'd5);
    for (int i = 0; i < 12; i++) pending_reqs.push_back(rand_pix());
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, 12'd4);
    queue_frame(5, 4, 0);

    wait_idle();
    if (error_count == 0) $display("rgb_sobel_edge_magnitude verification clean");
    else $display("rgb_sobel_edge_magnitude verification failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("rgb_sobel_edge_magnitude verification failed");
    $finish;
  end

endmodule
